[rtl/bankers_safety_check_core_defines.svh]
// ----------------------------------------------------------------------------
// Banker's safety check assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define BSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// Banker's safety check package
// Shared widths, defaults and codes for the safety check core and channels.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Default sizing
  localparam int BSC_MAX_PROCESSES = 16;
  localparam int BSC_MAX_RESOURCES = 8;
  localparam int BSC_AMOUNT_WIDTH  = 8;

  // Fixed field widths
  localparam int REQ_W    = 2;
  localparam int PIDX_W   = 4;
  localparam int RIDX_W   = 3;
  localparam int AMT_IN_W = 8;
  localparam int PID_W    = 4;
  localparam int WORK_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_NP_W   = 5;
  localparam int CFG_NR_W   = 4;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_NP_RESET = 16;
  localparam int CFG_NR_RESET = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PROCESSES = 1'b0,
    CFG_NUM_RESOURCES = 1'b1
  } cfg_reg_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_AVAIL = 2'd0,
    REQ_LOAD_PROC  = 2'd1,
    REQ_EVALUATE   = 2'd2
  } req_type_t;

endpackage

[rtl/bsc_in_if.sv]
// ----------------------------------------------------------------------------
// Banker's safety check request channel
// Valid/ready channel carrying one load or evaluate word.
// ----------------------------------------------------------------------------
interface bsc_in_if import bsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [PIDX_W-1:0]   process_index;
  logic [RIDX_W-1:0]   resource_index;
  logic [AMT_IN_W-1:0] allocated_amount;
  logic [AMT_IN_W-1:0] maximum_amount;
  logic [AMT_IN_W-1:0] available_amount;

  modport source (
    output valid, req_type, process_index, resource_index,
           allocated_amount, maximum_amount, available_amount,
    input  ready
  );

  modport sink (
    input  valid, req_type, process_index, resource_index,
           allocated_amount, maximum_amount, available_amount,
    output ready
  );
endinterface

[rtl/bsc_out_if.sv]
// ----------------------------------------------------------------------------
// Banker's safety check result channel
// Valid/ready channel carrying one word of the safe order or the unsafe flag.
// ----------------------------------------------------------------------------
interface bsc_out_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PID_W-1:0] process_id;
  logic             safe;
  logic             last;

  modport source (
    output valid, process_id, safe, last,
    input  ready
  );

  modport sink (
    input  valid, process_id, safe, last,
    output ready
  );
endinterface

[rtl/bankers_safety_check_core.sv]
// ----------------------------------------------------------------------------
// Banker's safety check core
// Load available/allocated/maximum amounts, then evaluate for a safe order.
// ----------------------------------------------------------------------------
// Load words (available amount, or allocated and maximum of one process and
// resource) are taken one per cycle and produce no result. An evaluate word
// copies the available amounts into the work vector and walks the processes
// in index order, pass after pass, until all are finished or a pass grants
// nothing. The allocation and need amounts sit in one table memory, one
// {alloc, need} entry per process and resource, read one entry per cycle
// through a registered read port; that single read port sets the pace.
// Each process visit goes through selection, a check of its need row
// against work, an add of its allocation row into work when it is granted,
// and an advance (rows cover nr = resources in use). A safe run then
// emits np result words, one per cycle when the sink is ready; an unsafe run
// emits one word with safe low. The request channel is held off (ready low)
// from the evaluate word until the last result word is loaded into the
// output register; that register lets the next request in while the last
// word still waits for the sink. Register counts of zero act as one, counts
// above the maximum act as the maximum; load words with an index beyond the
// table are dropped, and request code 3 is dropped without a result.
// ----------------------------------------------------------------------------
`include "bankers_safety_check_core_defines.svh"

module bankers_safety_check_core import bsc_pkg::*; #(
  parameter int MAX_PROCESSES = BSC_MAX_PROCESSES,
  parameter int MAX_RESOURCES = BSC_MAX_RESOURCES,
  parameter int AMOUNT_WIDTH  = BSC_AMOUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bsc_in_if.sink                in_ch,
  bsc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIW       = $clog2(MAX_PROCESSES);
  localparam int RIW       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW       = $clog2(MAX_PROCESSES + 1);
  localparam int RCW       = $clog2(MAX_RESOURCES + 1);
  localparam int AW        = AMOUNT_WIDTH;
  localparam int MEM_DEPTH = MAX_PROCESSES * (2 ** RIW);
  localparam int MAW       = PIW + RIW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_CHK,
    ST_ADD,
    ST_ADV,
    ST_EMIT,
    ST_UNS
  } state_t;

  // Control state
  state_t               state_r, state_nxt;
  logic [CFG_NP_W-1:0]  cfg_np_r;
  logic [CFG_NR_W-1:0]  cfg_nr_r;
  logic [PIW-1:0]       p_r, p_nxt;
  logic [RCW-1:0]       ri_r, ri_nxt;
  logic                 rv_r, rv_nxt;
  logic [RIW-1:0]       rr_r, rr_nxt;
  logic [PCW-1:0]       done_r, done_nxt;
  logic [PCW-1:0]       e_r, e_nxt;
  logic                 granted_r, granted_nxt;
  logic [MAX_PROCESSES-1:0] fin_r, fin_nxt;
  logic                 ov_r, ov_nxt;
  logic [PID_W-1:0]     opid_r, opid_nxt;
  logic                 osafe_r, osafe_nxt;
  logic                 olast_r, olast_nxt;

  // Storage
  logic [2*AW-1:0]      tab_mem [MEM_DEPTH];
  logic [2*AW-1:0]      rdata_r;
  logic [AW-1:0]        avail_r [MAX_RESOURCES];
  logic [WORK_W-1:0]    work_r  [MAX_RESOURCES];
  logic [PID_W-1:0]     order_r [MAX_PROCESSES];

  // Clamped counts
  logic [31:0]          np_32, nr_32;
  logic [PCW-1:0]       np_c;
  logic [RCW-1:0]       nr_c;

  // Load decode
  logic                 in_fire;
  logic [31:0]          in_pidx32, in_ridx32;
  logic [31:0]          in_alloc32, in_max32, in_avail32;
  logic [AW-1:0]        ld_alloc, ld_max, ld_avail, ld_need;
  logic                 p_ok, r_ok;
  logic                 avail_we, mem_we;
  logic [MAW-1:0]       mem_waddr, mem_raddr;
  logic [2*AW-1:0]      mem_wdata;

  // Evaluation datapath
  logic [AW-1:0]        rd_need, rd_alloc;
  logic [WORK_W-1:0]    work_cur, work_sat;
  logic [WORK_W:0]      sum_w;
  logic                 need_fits, rr_last, p_last, issue, slot_free;
  logic [PID_W-1:0]     order_rd;
  logic                 work_init, work_we, order_we;

  // --------------------------------------------------------------------------
  // Counts in use: zero acts as one, anything above the maximum saturates.
  // --------------------------------------------------------------------------
  always_comb begin
    if (cfg_np_r == '0) begin
      np_32 = 32'd1;
    end else if (32'(cfg_np_r) > 32'(MAX_PROCESSES)) begin
      np_32 = 32'(MAX_PROCESSES);
    end else begin
      np_32 = 32'(cfg_np_r);
    end
    if (cfg_nr_r == '0) begin
      nr_32 = 32'd1;
    end else if (32'(cfg_nr_r) > 32'(MAX_RESOURCES)) begin
      nr_32 = 32'(MAX_RESOURCES);
    end else begin
      nr_32 = 32'(cfg_nr_r);
    end
  end

  assign np_c = np_32[PCW-1:0];
  assign nr_c = nr_32[RCW-1:0];

  // --------------------------------------------------------------------------
  // Request side: accept only while idle; loads write straight into storage.
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_pidx32  = 32'(in_ch.process_index);
  assign in_ridx32  = 32'(in_ch.resource_index);
  assign in_alloc32 = 32'(in_ch.allocated_amount);
  assign in_max32   = 32'(in_ch.maximum_amount);
  assign in_avail32 = 32'(in_ch.available_amount);

  // Mask loaded amounts to the amount width
  assign ld_alloc = in_alloc32[AW-1:0];
  assign ld_max   = in_max32[AW-1:0];
  assign ld_avail = in_avail32[AW-1:0];
  assign ld_need  = (ld_max > ld_alloc) ? (ld_max - ld_alloc) : '0;

  assign p_ok = in_pidx32 < 32'(MAX_PROCESSES);
  assign r_ok = in_ridx32 < 32'(MAX_RESOURCES);

  assign avail_we  = in_fire && (in_ch.req_type == REQ_LOAD_AVAIL) && r_ok;
  assign mem_we    = in_fire && (in_ch.req_type == REQ_LOAD_PROC) && p_ok && r_ok;
  assign mem_waddr = {in_pidx32[PIW-1:0], in_ridx32[RIW-1:0]};
  assign mem_wdata = {ld_alloc, ld_need};

  // Walk the row of the current process, one resource per cycle
  assign mem_raddr = {p_r, ri_r[RIW-1:0]};

  // --------------------------------------------------------------------------
  // Evaluation datapath: rdata_r holds the entry of resource rr_r when rv_r.
  // --------------------------------------------------------------------------
  assign rd_need   = rdata_r[AW-1:0];
  assign rd_alloc  = rdata_r[2*AW-1:AW];
  assign work_cur  = work_r[rr_r];
  assign need_fits = WORK_W'(rd_need) <= work_cur;
  assign sum_w     = {1'b0, work_cur} + (WORK_W + 1)'(rd_alloc);
  assign work_sat  = sum_w[WORK_W] ? '1 : sum_w[WORK_W-1:0];

  assign rr_last   = (RCW'(rr_r) == (nr_c - RCW'(1)));
  assign p_last    = (PCW'(p_r) == (np_c - PCW'(1)));
  assign issue     = (ri_r < nr_c);
  assign order_rd  = order_r[e_r[PIW-1:0]];
  assign slot_free = !ov_r || out_ch.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    p_nxt       = p_r;
    ri_nxt      = ri_r;
    rv_nxt      = rv_r;
    rr_nxt      = rr_r;
    done_nxt    = done_r;
    e_nxt       = e_r;
    granted_nxt = granted_r;
    fin_nxt     = fin_r;
    ov_nxt      = ov_r && !out_ch.ready;
    opid_nxt    = opid_r;
    osafe_nxt   = osafe_r;
    olast_nxt   = olast_r;
    work_init   = 1'b0;
    work_we     = 1'b0;
    order_we    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Start a run: load work from available, clear the finished flags
        if (in_fire && (in_ch.req_type == REQ_EVALUATE)) begin
          work_init   = 1'b1;
          fin_nxt     = '0;
          p_nxt       = '0;
          done_nxt    = '0;
          granted_nxt = 1'b0;
          state_nxt   = ST_SEL;
        end
      end

      ST_SEL: begin
        ri_nxt = '0;
        rv_nxt = 1'b0;
        if (fin_r[p_r]) begin
          state_nxt = ST_ADV;
        end else begin
          state_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        // Stream the need row and compare against work
        rv_nxt = issue;
        rr_nxt = ri_r[RIW-1:0];
        if (issue) begin
          ri_nxt = ri_r + RCW'(1);
        end
        if (rv_r) begin
          if (!need_fits) begin
            rv_nxt    = 1'b0;
            state_nxt = ST_ADV;
          end else if (rr_last) begin
            ri_nxt    = '0;
            rv_nxt    = 1'b0;
            state_nxt = ST_ADD;
          end
        end
      end

      ST_ADD: begin
        // Stream the allocation row into work, saturating
        rv_nxt = issue;
        rr_nxt = ri_r[RIW-1:0];
        if (issue) begin
          ri_nxt = ri_r + RCW'(1);
        end
        if (rv_r) begin
          work_we = 1'b1;
          if (rr_last) begin
            fin_nxt[p_r] = 1'b1;
            order_we     = 1'b1;
            done_nxt     = done_r + PCW'(1);
            granted_nxt  = 1'b1;
            rv_nxt       = 1'b0;
            state_nxt    = ST_ADV;
          end
        end
      end

      ST_ADV: begin
        // End of pass: finish, give up, or start another pass
        if (p_last) begin
          if (done_r == np_c) begin
            e_nxt     = '0;
            state_nxt = ST_EMIT;
          end else if (!granted_r) begin
            state_nxt = ST_UNS;
          end else begin
            p_nxt       = '0;
            granted_nxt = 1'b0;
            state_nxt   = ST_SEL;
          end
        end else begin
          p_nxt     = p_r + PIW'(1);
          state_nxt = ST_SEL;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          opid_nxt  = order_rd;
          osafe_nxt = 1'b1;
          olast_nxt = (e_r == (np_c - PCW'(1)));
          if (e_r == (np_c - PCW'(1))) begin
            state_nxt = ST_IDLE;
          end else begin
            e_nxt = e_r + PCW'(1);
          end
        end
      end

      ST_UNS: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          opid_nxt  = '0;
          osafe_nxt = 1'b0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_np_r  <= CFG_NP_W'(CFG_NP_RESET);
      cfg_nr_r  <= CFG_NR_W'(CFG_NR_RESET);
      p_r       <= '0;
      ri_r      <= '0;
      rv_r      <= 1'b0;
      rr_r      <= '0;
      done_r    <= '0;
      e_r       <= '0;
      granted_r <= 1'b0;
      fin_r     <= '0;
      ov_r      <= 1'b0;
      opid_r    <= '0;
      osafe_r   <= 1'b0;
      olast_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_r       <= p_nxt;
      ri_r      <= ri_nxt;
      rv_r      <= rv_nxt;
      rr_r      <= rr_nxt;
      done_r    <= done_nxt;
      e_r       <= e_nxt;
      granted_r <= granted_nxt;
      fin_r     <= fin_nxt;
      ov_r      <= ov_nxt;
      opid_r    <= opid_nxt;
      osafe_r   <= osafe_nxt;
      olast_r   <= olast_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_PROCESSES: cfg_np_r <= cfg_wdata[CFG_NP_W-1:0];
          CFG_NUM_RESOURCES: cfg_nr_r <= cfg_wdata[CFG_NR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Alloc/need table: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tab_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= tab_mem[mem_raddr];
  end

  // Available, work and order storage
  always_ff @(posedge clk) begin
    if (avail_we) begin
      avail_r[in_ridx32[RIW-1:0]] <= ld_avail;
    end
    if (work_init) begin
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        work_r[i] <= WORK_W'(avail_r[i]);
      end
    end else if (work_we) begin
      work_r[rr_r] <= work_sat;
    end
    if (order_we) begin
      order_r[done_r[PIW-1:0]] <= PID_W'(p_r);
    end
  end

  // Result channel
  assign out_ch.valid      = ov_r;
  assign out_ch.process_id = opid_r;
  assign out_ch.safe       = osafe_r;
  assign out_ch.last       = olast_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BSC_ASSERT_ALWAYS(a_fin_count, $countones(fin_r) == int'(done_r), "finished flags disagree with grant count")
  `BSC_ASSERT_IMPLY(a_rdata_phase, rv_r, (state_r == ST_CHK) || (state_r == ST_ADD), "table read data live outside a row walk")
  `BSC_ASSERT_IMPLY(a_unsafe_word, ov_r && !osafe_r, olast_r && (opid_r == '0), "unsafe word not a lone final zero")

endmodule

[tb/bankers_safety_check_core_test.sv]
// ----------------------------------------------------------------------------
// Banker's safety check core testbench
// Drives load and evaluate words through the request channel, predicts the
// safe order (or the unsafe flag) from a local copy of the tables, and checks
// every result word field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module bankers_safety_check_core_test import bsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the core drops without a result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Ways of drawing table contents for one evaluation.
  localparam int STYLE_TIGHT    = 0;  // small free pool, larger needs
  localparam int STYLE_GENEROUS = 1;  // large pool, small needs
  localparam int STYLE_FREE     = 2;  // anything in range
  localparam int STYLE_EXTREME  = 3;  // only zero and full scale

  localparam int RANDOM_WORDS   = 12;
  localparam int QUIET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct packed {
    logic [PID_W-1:0] process_id;
    logic             safe;
    logic             last;
  } order_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bsc_in_if  in_ch ();
  bsc_out_if out_ch ();

  bankers_safety_check_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the core's tables and count registers.
  logic [WORK_W-1:0]   avail_pool   [BSC_MAX_RESOURCES];
  logic [AMT_IN_W-1:0] alloc_amts   [BSC_MAX_PROCESSES][BSC_MAX_RESOURCES];
  logic [AMT_IN_W-1:0] need_amts    [BSC_MAX_PROCESSES][BSC_MAX_RESOURCES];
  bit                  avail_loaded [BSC_MAX_RESOURCES];
  bit                  entry_loaded [BSC_MAX_PROCESSES][BSC_MAX_RESOURCES];
  logic [CFG_NP_W-1:0] np_count = CFG_NP_W'(CFG_NP_RESET);
  logic [CFG_NR_W-1:0] nr_count = CFG_NR_W'(CFG_NR_RESET);

  // Result words still owed by the core, oldest first.
  order_word_t pending_order_words [$];

  int words_sent;
  int fail_count = 0;
  int idle_cycles;
  int sink_hold;
  int sink_draw;
  bit src_eager;
  bit sink_eager;
  order_word_t want;

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Counts in use; zero acts as one, anything above the table acts as the table.
  function automatic int procs_in_use();
    if (np_count == 0) return 1;
    return (np_count > BSC_MAX_PROCESSES) ? BSC_MAX_PROCESSES : int'(np_count);
  endfunction

  function automatic int res_in_use();
    if (nr_count == 0) return 1;
    return (nr_count > BSC_MAX_RESOURCES) ? BSC_MAX_RESOURCES : int'(nr_count);
  endfunction

  // Run the safety walk on the local tables and queue the words it yields.
  function automatic void predict_safe_order();
    int np;
    int nr;
    int ndone;
    int sum;
    bit granted;
    bit fits;
    logic [WORK_W-1:0] work [BSC_MAX_RESOURCES];
    bit finished [BSC_MAX_PROCESSES];
    logic [PID_W-1:0] order [BSC_MAX_PROCESSES];
    order_word_t w;
    np = procs_in_use();
    nr = res_in_use();
    ndone = 0;
    granted = 1'b1;
    foreach (finished[i]) finished[i] = 1'b0;
    foreach (work[i]) work[i] = (i < nr) ? avail_pool[i] : '0;
    // Pass after pass in index order; stop when a pass grants nothing.
    while (ndone < np && granted) begin
      granted = 1'b0;
      for (int p = 0; p < np; p++) begin
        if (finished[p]) continue;
        fits = 1'b1;
        for (int r = 0; r < nr; r++)
          if (need_amts[p][r] > work[r]) fits = 1'b0;
        if (!fits) continue;
        for (int r = 0; r < nr; r++) begin
          sum = int'(work[r]) + int'(alloc_amts[p][r]);
          work[r] = (sum > 16'hFFFF) ? 16'hFFFF : WORK_W'(sum);
        end
        finished[p] = 1'b1;
        order[ndone] = PID_W'(p);
        ndone++;
        granted = 1'b1;
      end
    end
    if (ndone < np) begin
      w.process_id = '0;
      w.safe = 1'b0;
      w.last = 1'b1;
      pending_order_words = {pending_order_words, w};
    end else begin
      for (int i = 0; i < np; i++) begin
        w.process_id = order[i];
        w.safe = 1'b1;
        w.last = (i == np - 1);
        pending_order_words = {pending_order_words, w};
      end
    end
  endfunction

  // Fold one accepted request word into the local tables.
  function automatic void track_word(logic [REQ_W-1:0] kind, logic [PIDX_W-1:0] pidx,
                                     logic [RIDX_W-1:0] ridx, logic [AMT_IN_W-1:0] alloc_amt,
                                     logic [AMT_IN_W-1:0] max_amt,
                                     logic [AMT_IN_W-1:0] avail_amt);
    case (kind)
      REQ_LOAD_AVAIL: begin
        avail_pool[ridx] = WORK_W'(avail_amt);
        avail_loaded[ridx] = 1'b1;
      end
      REQ_LOAD_PROC: begin
        alloc_amts[pidx][ridx] = alloc_amt;
        need_amts[pidx][ridx] = (max_amt > alloc_amt) ? max_amt - alloc_amt : '0;
        entry_loaded[pidx][ridx] = 1'b1;
      end
      REQ_EVALUATE: predict_safe_order();
      default: ;
    endcase
  endfunction

  // Send one request word after a random gap, and hold it until accepted.
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [PIDX_W-1:0] pidx,
                           input logic [RIDX_W-1:0] ridx, input logic [AMT_IN_W-1:0] alloc_amt,
                           input logic [AMT_IN_W-1:0] max_amt,
                           input logic [AMT_IN_W-1:0] avail_amt);
    int gap;
    gap = src_eager ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.req_type         <= kind;
    in_ch.process_index    <= pidx;
    in_ch.resource_index   <= ridx;
    in_ch.allocated_amount <= alloc_amt;
    in_ch.maximum_amount   <= max_amt;
    in_ch.available_amount <= avail_amt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_word(kind, pidx, ridx, alloc_amt, max_amt, avail_amt);
    if (kind != REQ_UNUSED) words_sent++;
  endtask

  // Drop valid, wait for every owed word, then let the core go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_order_words.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write both count registers on back-to-back edges; only call while idle.
  task automatic write_counts(input logic [CFG_DATA_W-1:0] np_value,
                              input logic [CFG_DATA_W-1:0] nr_value);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_PROCESSES;
    cfg_wdata <= np_value;
    @(posedge clk);
    np_count = np_value[CFG_NP_W-1:0];
    cfg_index <= CFG_NUM_RESOURCES;
    cfg_wdata <= nr_value;
    @(posedge clk);
    nr_count = nr_value[CFG_NR_W-1:0];
    cfg_we <= 1'b0;
  endtask

  function automatic logic [AMT_IN_W-1:0] draw_avail(int style);
    case (style)
      STYLE_TIGHT:    return AMT_IN_W'($urandom_range(0, 30));
      STYLE_GENEROUS: return AMT_IN_W'($urandom_range(100, 255));
      STYLE_EXTREME:  return $urandom_range(0, 1) ? '1 : '0;
      default:        return AMT_IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void draw_entry(int style, output logic [AMT_IN_W-1:0] alloc_amt,
                                     output logic [AMT_IN_W-1:0] max_amt);
    int top;
    case (style)
      STYLE_TIGHT: begin
        alloc_amt = AMT_IN_W'($urandom_range(0, 60));
        top = int'(alloc_amt) + $urandom_range(0, 80);
      end
      STYLE_GENEROUS: begin
        alloc_amt = AMT_IN_W'($urandom_range(0, 255));
        top = int'(alloc_amt) + $urandom_range(0, 8);
      end
      STYLE_EXTREME: begin
        alloc_amt = $urandom_range(0, 1) ? '1 : '0;
        top = $urandom_range(0, 1) ? 255 : 0;
      end
      default: begin
        alloc_amt = AMT_IN_W'($urandom_range(0, 255));
        top = $urandom_range(0, 255);
      end
    endcase
    max_amt = (top > 255) ? '1 : AMT_IN_W'(top);
  endfunction

  // One evaluation: refresh the tables in use (always the unloaded entries,
  // the rest by chance, sparsely when the table is big), sprinkle noise, then
  // evaluate with junk in the unused fields.
  task automatic run_case(input int style);
    int np;
    int nr;
    int keep;
    logic [AMT_IN_W-1:0] alloc_amt;
    logic [AMT_IN_W-1:0] max_amt;
    np = procs_in_use();
    nr = res_in_use();
    keep = (np * nr > 16) ? 1 : 6;
    for (int r = 0; r < nr; r++)
      if (!avail_loaded[r] || $urandom_range(0, 7) < keep)
        send_word(REQ_LOAD_AVAIL, PIDX_W'($urandom), RIDX_W'(r), AMT_IN_W'($urandom),
                  AMT_IN_W'($urandom), draw_avail(style));
    for (int p = 0; p < np; p++)
      for (int r = 0; r < nr; r++)
        if (!entry_loaded[p][r] || $urandom_range(0, 7) < keep) begin
          draw_entry(style, alloc_amt, max_amt);
          send_word(REQ_LOAD_PROC, PIDX_W'(p), RIDX_W'(r), alloc_amt, max_amt,
                    AMT_IN_W'($urandom));
        end
    // Noise: dropped request codes and stray loads anywhere in the table.
    repeat ($urandom_range(0, 2))
      send_word($urandom_range(0, 1) ? REQ_UNUSED :
                ($urandom_range(0, 1) ? REQ_LOAD_AVAIL : REQ_LOAD_PROC),
                PIDX_W'($urandom), RIDX_W'($urandom), AMT_IN_W'($urandom),
                AMT_IN_W'($urandom), AMT_IN_W'($urandom));
    send_word(REQ_EVALUATE, PIDX_W'($urandom), RIDX_W'($urandom), AMT_IN_W'($urandom),
              AMT_IN_W'($urandom), AMT_IN_W'($urandom));
  endtask

  // Hand-built tables: out-of-order grants, allocation above maximum, an
  // unsafe state, a dropped request code, extreme fields and a single process.
  task automatic test_directed();
    write_counts(5'd3, 5'd2);
    send_word(REQ_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd1);
    send_word(REQ_LOAD_AVAIL, 4'd0, 3'd1, 8'd0, 8'd0, 8'd0);
    // Process 0 needs more than is free; it can only go after 1 returns its allocation.
    send_word(REQ_LOAD_PROC, 4'd0, 3'd0, 8'd0, 8'd200, 8'd0);
    send_word(REQ_LOAD_PROC, 4'd0, 3'd1, 8'd0, 8'd0, 8'd0);
    send_word(REQ_LOAD_PROC, 4'd1, 3'd0, 8'd255, 8'd255, 8'd0);
    // Allocation above maximum: need clamps at zero.
    send_word(REQ_LOAD_PROC, 4'd1, 3'd1, 8'd10, 8'd5, 8'd0);
    send_word(REQ_LOAD_PROC, 4'd2, 3'd0, 8'd7, 8'd7, 8'd0);
    send_word(REQ_LOAD_PROC, 4'd2, 3'd1, 8'd0, 8'd0, 8'd0);
    send_word(REQ_EVALUATE, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255);
    send_word(REQ_UNUSED, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255);
    // Process 0 now wants 11 of resource 1 while only 10 ever come back: unsafe.
    send_word(REQ_LOAD_PROC, 4'd0, 3'd1, 8'd0, 8'd11, 8'd0);
    send_word(REQ_EVALUATE, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(REQ_LOAD_PROC, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255);
    send_word(REQ_LOAD_AVAIL, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255);
    settle();
    // Single process, single resource: safe, then one unit short.
    write_counts(5'd1, 5'd1);
    send_word(REQ_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd200);
    send_word(REQ_EVALUATE, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(REQ_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd199);
    send_word(REQ_EVALUATE, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
    settle();
  endtask

  // Count registers at and beyond their limits, and the full table.
  task automatic test_count_limits();
    // Zero processes acts as one; resource data 16 keeps only its low bits.
    write_counts(5'd0, 5'd16);
    send_word(REQ_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd255);
    send_word(REQ_EVALUATE, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
    settle();
    // Over the top on both: acts as the whole table.
    write_counts(5'd31, 5'd31);
    run_case(STYLE_GENEROUS);
    settle();
    // Exact maxima, no gaps on either side.
    src_eager = 1'b1;
    sink_eager = 1'b1;
    write_counts(5'd16, 5'd8);
    run_case(STYLE_TIGHT);
    src_eager = 1'b0;
    sink_eager = 1'b0;
    settle();
  endtask

  // Random phases: new counts between some phases, a few evaluations per phase,
  // back to back, with stall modes that change from phase to phase.
  task automatic test_random_mix();
    int start;
    int pick;
    logic [CFG_DATA_W-1:0] np_value;
    logic [CFG_DATA_W-1:0] nr_value;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      settle();
      src_eager = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 11);
        np_value = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : (pick == 2) ? 5'd16 :
                   CFG_DATA_W'($urandom_range(1, 5));
        pick = $urandom_range(0, 9);
        nr_value = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd15 : (pick == 2) ? 5'd8 :
                   CFG_DATA_W'($urandom_range(1, 3));
        write_counts(np_value, nr_value);
      end
      repeat ($urandom_range(1, 3)) run_case($urandom_range(STYLE_TIGHT, STYLE_EXTREME));
    end
  endtask

  // Result side: take words with random stalls, check each against the
  // oldest owed word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_order_words.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("unexpected result word: pid %0d safe %0b last %0b",
                     out_ch.process_id, out_ch.safe, out_ch.last);
        end else begin
          want = pending_order_words.pop_front();
          if (out_ch.process_id !== want.process_id || out_ch.safe !== want.safe ||
              out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= SHOWN_ERRORS)
              $display("mismatch: exp pid %0d safe %0b last %0b, got pid %0d safe %0b last %0b",
                       want.process_id, want.safe, want.last,
                       out_ch.process_id, out_ch.safe, out_ch.last);
          end
        end
        // Draw the stall before the next word.
        sink_draw = sink_eager ? 0 : $urandom_range(0, 16);
        sink_hold <= sink_draw;
        out_ch.ready <= (sink_draw == 0);
      end else if (sink_hold > 1) begin
        sink_hold <= sink_hold - 1;
      end else begin
        sink_hold <= 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bankers_safety_check_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Hold every request-side input known from time zero.
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_NUM_PROCESSES;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.req_type         = REQ_LOAD_AVAIL;
    in_ch.process_index    = '0;
    in_ch.resource_index   = '0;
    in_ch.allocated_amount = '0;
    in_ch.maximum_amount   = '0;
    in_ch.available_amount = '0;
    words_sent             = 0;
    src_eager              = 1'b0;
    sink_eager             = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_count_limits();
    test_random_mix();

    // Drain: wait for every owed word and a quiet tail.
    settle();
    if (fail_count == 0 && pending_order_words.size() == 0) begin
      $display("bankers_safety_check_core verification clean");
    end else begin
      $display("bankers_safety_check_core verification failed");
    end
    $finish;
  end

endmodule
